// ----- hw/rtl/embedding_table_train_defines.svh -----
// Assertion macros shared by the embedding table engine.
`ifndef EMBEDDING_TABLE_TRAIN_DEFINES_SVH
`define EMBEDDING_TABLE_TRAIN_DEFINES_SVH

// Concurrent assertion sampled on the rising clock, switched off while reset is low.
`define ETT_ASSERT_ARST(label, clk_s, rstn_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error(msg);

// Concurrent assertion sampled on the rising clock, also checked during reset.
`define ETT_ASSERT_CLK(label, clk_s, prop, msg) \
	label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- hw/rtl/ett_pkg.sv -----
// Shared types and constants of the embedding table engine.
package ett_pkg;

	// Field widths of the item and result formats.
	localparam int CMD_W    = 2;
	localparam int TOKEN_W  = 16;
	localparam int COLUMN_W = 6;
	localparam int WEIGHT_W = 16;
	localparam int GRAD_W   = 24;
	localparam int LR_W     = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int VOCAB_W  = 11;
	localparam int DIM_W    = 7;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACCUMULATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UPDATE     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE      = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VOCAB_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_IN_USE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 2'd2;

	// Write enables of the two stores.
	typedef struct packed {
		logic wt_we;
		logic grad_we;
	} store_wr_t;

	// Results of the shared arithmetic unit.
	typedef struct packed {
		logic                       nz;
		logic signed [WEIGHT_W-1:0] new_weight;
		logic signed [GRAD_W-1:0]   acc_grad;
	} arith_res_t;

endpackage

// ----- hw/rtl/ett_stream_if.sv -----
// Valid/ready channels carrying command items in and weight results out.
interface ett_in_if;
	logic                                valid;
	logic                                ready;
	logic [ett_pkg::CMD_W-1:0]           cmd;
	logic [ett_pkg::TOKEN_W-1:0]         token_id;
	logic [ett_pkg::COLUMN_W-1:0]        column;
	logic signed [ett_pkg::WEIGHT_W-1:0] value;

	modport source (output valid, cmd, token_id, column, value, input ready);
	modport sink (input valid, cmd, token_id, column, value, output ready);
endinterface

interface ett_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ett_pkg::WEIGHT_W-1:0] weight_value;
	logic                                last;

	modport source (output valid, weight_value, last, input ready);
	modport sink (input valid, weight_value, last, output ready);
endinterface

// ----- hw/rtl/embedding_table_train.sv -----
// Embedding table engine top level: sequencer, configuration and result register.
// After acceptance a lookup runs a read and a wait state per element of the effective dim_in_use;
// accumulate runs read, arithmetic and write states, write its write state, update a sweep of the
// whole store, a flush and a completion; the next item is taken in the idle state. A skipped
// accumulate or write goes straight back to idle, and a full result register stalls lookups and
// the update completion. After reset the gradient memory is cleared one entry a cycle, no item taken.
`include "embedding_table_train_defines.svh"

module embedding_table_train #(
	parameter int VOCAB_DEPTH = 1024,
	parameter int MAX_DIM     = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ett_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ett_pkg::CFG_W-1:0]        cfg_data,
	ett_in_if.sink                           in_ch,
	ett_out_if.source                        out_ch
);
	localparam int STORE_SIZE = VOCAB_DEPTH * MAX_DIM;
	localparam int AW         = $clog2(STORE_SIZE);
	localparam int RW         = $clog2(VOCAB_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);
	localparam logic [16:0] VOCAB_LIM = 17'(VOCAB_DEPTH);
	localparam logic [ett_pkg::DIM_W-1:0] DIM_LIM = ett_pkg::DIM_W'(MAX_DIM);

	// Sequencer state codes.
	localparam logic [3:0] ST_CLR       = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_LK_RD     = 4'd2;
	localparam logic [3:0] ST_LK_WAIT   = 4'd3;
	localparam logic [3:0] ST_ACC_RD    = 4'd4;
	localparam logic [3:0] ST_ACC_AR    = 4'd5;
	localparam logic [3:0] ST_ACC_WR    = 4'd6;
	localparam logic [3:0] ST_WRT       = 4'd7;
	localparam logic [3:0] ST_UPD       = 4'd8;
	localparam logic [3:0] ST_UPD_FLUSH = 4'd9;
	localparam logic [3:0] ST_UPD_DONE  = 4'd10;

	logic [3:0]                          state_q;
	logic [ett_pkg::VOCAB_W-1:0]         vocab_q;
	logic [ett_pkg::DIM_W-1:0]           dim_q;
	logic [ett_pkg::LR_W-1:0]            lr_q;
	logic [RW-1:0]                       row_q;
	logic [ett_pkg::COLUMN_W-1:0]        col_q;
	logic signed [ett_pkg::WEIGHT_W-1:0] val_q;
	logic [AW-1:0]                       sweep_q;
	logic                                v_s1_q;
	logic                                v_s2_q;
	logic [AW-1:0]                       addr_s1;
	logic [AW-1:0]                       addr_s2;
	logic                                out_valid_q;
	logic signed [ett_pkg::WEIGHT_W-1:0] out_wv_q;
	logic                                out_last_q;

	logic [16:0]                         eff_vocab;
	logic [ett_pkg::DIM_W-1:0]           eff_dim;
	logic                                tok_ok;
	logic                                col_ok;
	logic                                accept;
	logic                                lk_last;
	logic                                out_free;
	logic                                out_load;
	logic [AW-1:0]                       item_addr;
	ett_pkg::store_wr_t                  st_wr;
	logic [AW-1:0]                       st_waddr;
	logic signed [ett_pkg::WEIGHT_W-1:0] st_wt_wdata;
	logic signed [ett_pkg::GRAD_W-1:0]   st_grad_wdata;
	logic [AW-1:0]                       st_raddr;
	logic signed [ett_pkg::WEIGHT_W-1:0] wt_rd;
	logic signed [ett_pkg::GRAD_W-1:0]   grad_rd;
	ett_pkg::arith_res_t                 ar_res;

	// Effective table shape from the configuration registers.
	always_comb begin
		eff_vocab = ({6'b0, vocab_q} > VOCAB_LIM) ? VOCAB_LIM : {6'b0, vocab_q};
		if (dim_q == '0) begin
			eff_dim = ett_pkg::DIM_W'(1);
		end else if (dim_q > DIM_LIM) begin
			eff_dim = DIM_LIM;
		end else begin
			eff_dim = dim_q;
		end
	end

	assign tok_ok    = {1'b0, in_ch.token_id} < eff_vocab;
	assign col_ok    = {1'b0, in_ch.column} < eff_dim;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept    = in_ch.valid && in_ch.ready;
	assign item_addr = AW'(row_q) * AW'(MAX_DIM) + AW'(col_q);
	assign lk_last   = ({1'b0, col_q} + ett_pkg::DIM_W'(1)) == eff_dim;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign out_load  = out_free && (state_q == ST_LK_WAIT || state_q == ST_UPD_DONE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q <= ett_pkg::VOCAB_W'(1024);
			dim_q   <= ett_pkg::DIM_W'(64);
			lr_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ett_pkg::REG_VOCAB_IN_USE: vocab_q <= cfg_data[ett_pkg::VOCAB_W-1:0];
				ett_pkg::REG_DIM_IN_USE:   dim_q   <= cfg_data[ett_pkg::DIM_W-1:0];
				ett_pkg::REG_LEARN_RATE:   lr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item fields held for the duration of a command; the column steps through a lookup.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= tok_ok ? in_ch.token_id[RW-1:0] : '0;
			col_q <= (in_ch.cmd == ett_pkg::CMD_LOOKUP) ? '0 : in_ch.column;
			val_q <= in_ch.value;
		end else if (state_q == ST_LK_WAIT && out_free && !lk_last) begin
			col_q <= col_q + ett_pkg::COLUMN_W'(1);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			sweep_q <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					if (sweep_q == LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (in_ch.cmd)
							ett_pkg::CMD_LOOKUP:     state_q <= ST_LK_RD;
							ett_pkg::CMD_ACCUMULATE: state_q <= (tok_ok && col_ok)
								? ST_ACC_RD : ST_IDLE;
							ett_pkg::CMD_UPDATE:     state_q <= ST_UPD;
							ett_pkg::CMD_WRITE:      state_q <= (tok_ok && col_ok)
								? ST_WRT : ST_IDLE;
							default:                 state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LK_RD:  state_q <= ST_LK_WAIT;
				ST_LK_WAIT: begin
					if (out_free) begin
						state_q <= lk_last ? ST_IDLE : ST_LK_RD;
					end
				end
				ST_ACC_RD: state_q <= ST_ACC_AR;
				ST_ACC_AR: state_q <= ST_ACC_WR;
				ST_ACC_WR: state_q <= ST_IDLE;
				ST_WRT:    state_q <= ST_IDLE;
				ST_UPD: begin
					if (sweep_q == LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_UPD_FLUSH;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_UPD_FLUSH: begin
					if (!v_s1_q && !v_s2_q) begin
						state_q <= ST_UPD_DONE;
					end
				end
				ST_UPD_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sweep pipeline valid flags: read, then multiply, then write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_s1_q <= (state_q == ST_UPD);
			v_s2_q <= v_s1_q;
		end
	end

	// Sweep pipeline addresses.
	always_ff @(posedge clk) begin
		addr_s1 <= sweep_q;
		addr_s2 <= addr_s1;
	end

	// Memory write and read selection.
	always_comb begin
		st_wr         = '0;
		st_waddr      = item_addr;
		st_wt_wdata   = val_q;
		st_grad_wdata = '0;
		st_raddr      = (state_q == ST_UPD) ? sweep_q : item_addr;
		if (state_q == ST_CLR) begin
			st_wr.grad_we = 1'b1;
			st_waddr      = sweep_q;
		end else if (state_q == ST_WRT) begin
			st_wr.wt_we   = 1'b1;
		end else if (state_q == ST_ACC_WR) begin
			st_wr.grad_we = 1'b1;
			st_grad_wdata = ar_res.acc_grad;
		end else if (v_s2_q) begin
			st_wr.grad_we = 1'b1;
			st_wr.wt_we   = ar_res.nz;
			st_waddr      = addr_s2;
			st_wt_wdata   = ar_res.new_weight;
		end
	end

	ett_store #(
		.DEPTH (STORE_SIZE),
		.AW    (AW)
	) u_store (
		.clk        (clk),
		.wr         (st_wr),
		.waddr      (st_waddr),
		.wt_wdata   (st_wt_wdata),
		.grad_wdata (st_grad_wdata),
		.raddr      (st_raddr),
		.wt_rd      (wt_rd),
		.grad_rd    (grad_rd)
	);

	ett_arith u_arith (
		.clk    (clk),
		.grad   (grad_rd),
		.weight (wt_rd),
		.value  (val_q),
		.lr     (lr_q),
		.res    (ar_res)
	);

	// Result register: lets the next item in while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_wv_q   <= (state_q == ST_UPD_DONE) ? '0 : wt_rd;
			out_last_q <= (state_q == ST_UPD_DONE) ? 1'b1 : lk_last;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.weight_value = out_wv_q;
	assign out_ch.last         = out_last_q;

	// Checks on the sequencer.
	`ETT_ASSERT_CLK(a_reset_clear, clk,
		!arst_n |=> (state_q == ST_CLR && !out_valid_q && !v_s1_q && !v_s2_q),
		"reset does not leave the clearing pass with empty pipeline")
	`ETT_ASSERT_ARST(a_idle_sweep_zero, clk, arst_n, state_q == ST_IDLE |-> sweep_q == '0,
		"sweep counter not back at zero when idle")
	`ETT_ASSERT_ARST(a_no_wt_write_lookup, clk, arst_n,
		(state_q == ST_LK_RD || state_q == ST_LK_WAIT) |-> !st_wr.wt_we,
		"weight written during a lookup")
	`ETT_ASSERT_ARST(a_result_source, clk, arst_n,
		$rose(out_valid_q) |-> ($past(state_q) == ST_LK_WAIT || $past(state_q) == ST_UPD_DONE),
		"result loaded outside a lookup or update completion")
	`ETT_ASSERT_ARST(a_sweep_drained, clk, arst_n,
		state_q == ST_UPD_DONE |-> (!v_s1_q && !v_s2_q),
		"update reported done with write-backs in flight")
endmodule

// ----- hw/rtl/ett_arith.sv -----
// Shared arithmetic unit: SGD step on one entry and saturating gradient add.
module ett_arith (
	input  logic                                clk,
	input  logic signed [ett_pkg::GRAD_W-1:0]   grad,
	input  logic signed [ett_pkg::WEIGHT_W-1:0] weight,
	input  logic signed [ett_pkg::WEIGHT_W-1:0] value,
	input  logic [ett_pkg::LR_W-1:0]            lr,
	output ett_pkg::arith_res_t                 res
);
	localparam int PROD_W  = ett_pkg::GRAD_W + ett_pkg::LR_W + 1;
	localparam int DELTA_W = PROD_W - 16;
	localparam int NW_W    = DELTA_W + 1;
	localparam int SUM_W   = ett_pkg::GRAD_W + 1;

	logic signed [PROD_W-1:0]            prod_s1;
	logic signed [ett_pkg::WEIGHT_W-1:0] wt_s1;
	logic signed [ett_pkg::GRAD_W-1:0]   sum_s1;
	logic                                nz_s1;
	logic signed [SUM_W-1:0]             sum;
	logic signed [ett_pkg::GRAD_W-1:0]   sum_sat;
	logic signed [PROD_W-1:0]            rnd;
	logic signed [DELTA_W-1:0]           delta;
	logic signed [NW_W-1:0]              nw;

	// Saturating add of a Q4.12 element into a Q12.12 gradient.
	always_comb begin
		sum = SUM_W'(grad) + SUM_W'(value);
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			sum_sat = sum[SUM_W-1] ? {1'b1, {(ett_pkg::GRAD_W-1){1'b0}}}
				: {1'b0, {(ett_pkg::GRAD_W-1){1'b1}}};
		end else begin
			sum_sat = sum[ett_pkg::GRAD_W-1:0];
		end
	end

	// Multiply stage: gradient times learning rate, registered.
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(grad) * $signed({1'b0, lr});
		wt_s1   <= weight;
		sum_s1  <= sum_sat;
		nz_s1   <= (grad != '0);
	end

	// Round half up, subtract from the weight and saturate to Q4.12.
	always_comb begin
		rnd   = prod_s1 + PROD_W'(32768);
		delta = rnd[PROD_W-1:16];
		nw    = NW_W'(wt_s1) - NW_W'(delta);
		if (nw > NW_W'(32767)) begin
			res.new_weight = 16'sh7FFF;
		end else if (nw < -NW_W'(32768)) begin
			res.new_weight = 16'sh8000;
		end else begin
			res.new_weight = nw[ett_pkg::WEIGHT_W-1:0];
		end
		res.acc_grad = sum_s1;
		res.nz       = nz_s1;
	end
endmodule

// ----- hw/rtl/ett_store.sv -----
// Weight and gradient memories, one write port and one registered read port each.
module ett_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                                clk,
	input  ett_pkg::store_wr_t                  wr,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [ett_pkg::WEIGHT_W-1:0] wt_wdata,
	input  logic signed [ett_pkg::GRAD_W-1:0]   grad_wdata,
	input  logic [AW-1:0]                       raddr,
	output logic signed [ett_pkg::WEIGHT_W-1:0] wt_rd,
	output logic signed [ett_pkg::GRAD_W-1:0]   grad_rd
);
	logic signed [ett_pkg::WEIGHT_W-1:0] wt_mem [DEPTH];
	logic signed [ett_pkg::GRAD_W-1:0]   grad_mem [DEPTH];

	// Weight memory.
	always_ff @(posedge clk) begin
		if (wr.wt_we) begin
			wt_mem[waddr] <= wt_wdata;
		end
		wt_rd <= wt_mem[raddr];
	end

	// Gradient memory.
	always_ff @(posedge clk) begin
		if (wr.grad_we) begin
			grad_mem[waddr] <= grad_wdata;
		end
		grad_rd <= grad_mem[raddr];
	end
endmodule
